// ===== src/npf_pkg.sv =====
// Shared constants, state encoding and status types for the next-prime finder.
`timescale 1ns / 1ps
`default_nettype none

package npf_pkg;

  // Width of the start and answer ports.
  localparam int IO_WIDTH = 32;

  // Default search width.
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TRIAL,
    S_DIVIDE,
    S_NEXT,
    S_DONE
  } npf_state_t;

  // Status of the shared remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic is_zero;
  } npf_rem_stat_t;

endpackage

`default_nettype wire

// ===== src/npf_rem_unit.sv =====
// Iterative shift-subtract remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module npf_rem_unit
  import npf_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [DIV_WIDTH-1:0]   divisor,
  output npf_rem_stat_t               stat
);

  localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] dvd;
  logic [DIV_WIDTH-1:0]   rem;
  logic [DIV_WIDTH-1:0]   rem_next;
  logic [CNT_WIDTH-1:0]   cnt;
  logic                   busy;
  logic                   done;
  logic [DIV_WIDTH:0]     shifted;
  logic [DIV_WIDTH:0]     diff;

  // The remainder stays below the divisor, so the shifted value is below twice it.
  always_comb begin
    shifted = {rem, dvd[VALUE_WIDTH-1]};
    diff    = shifted - {1'b0, divisor};
    if (shifted >= {1'b0, divisor}) begin
      rem_next = diff[DIV_WIDTH-1:0];
    end else begin
      rem_next = shifted[DIV_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= dividend;
        rem  <= '0;
        cnt  <= CNT_WIDTH'(VALUE_WIDTH);
      end else if (busy) begin
        rem <= rem_next;
        dvd <= dvd << 1;
        cnt <= cnt - CNT_WIDTH'(1);
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy    = busy;
  assign stat.done    = done;
  assign stat.is_zero = (rem == '0);

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("remainder unit started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("remainder done without a finished run");

  a_keeps_running: assert property (@(posedge clk) disable iff (rst)
    busy && cnt != CNT_WIDTH'(1) |=> busy)
    else $error("remainder unit stopped early");

endmodule

`default_nettype wire

// ===== src/next_prime_finder.sv =====
// Top level of the next-prime finder: search sequencer and answer register.
`timescale 1ns / 1ps
`default_nettype none

// Returns the smallest prime at or above start_value, searching within the low
// VALUE_WIDTH bits; if none fits, no_prime is 1 and prime_value is 0. One
// transaction is worked at a time and in_ready is low until its answer has been
// taken. Candidates below two or even are skipped, two is reported as prime, and
// an odd candidate is tried against odd divisors, from three up to the first
// divisor that divides it or the last d with d * d not above it. All remainders
// go through one shift-subtract unit that retires one dividend bit per cycle.
module next_prime_finder
  import npf_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [IO_WIDTH-1:0] start_value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [IO_WIDTH-1:0]      prime_value,
  output logic                     no_prime
);

  localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int SQ_WIDTH  = VALUE_WIDTH + 2;

  npf_state_t state;
  npf_state_t state_next;

  logic [VALUE_WIDTH-1:0] cand;
  logic [DIV_WIDTH-1:0]   div_d;
  logic [SQ_WIDTH-1:0]    sq;
  npf_rem_stat_t          rem_stat;

  logic rem_start;
  logic load;
  logic step_cand;
  logic init_div;
  logic adv_div;
  logic set_found;
  logic set_fail;

  logic [VALUE_WIDTH+IO_WIDTH-1:0] start_ext;
  logic [VALUE_WIDTH+IO_WIDTH-1:0] cand_ext;

  assign start_ext = {{VALUE_WIDTH{1'b0}}, start_value};
  assign cand_ext  = {{IO_WIDTH{1'b0}}, cand};

  npf_rem_unit #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .DIV_WIDTH  (DIV_WIDTH)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .dividend(cand),
    .divisor (div_d),
    .stat    (rem_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rem_start  = 1'b0;
    load       = 1'b0;
    step_cand  = 1'b0;
    init_div   = 1'b0;
    adv_div    = 1'b0;
    set_found  = 1'b0;
    set_fail   = 1'b0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load       = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (cand < VALUE_WIDTH'(2)) begin
          state_next = S_NEXT;
        end else if (cand == VALUE_WIDTH'(2)) begin
          set_found  = 1'b1;
          state_next = S_DONE;
        end else if (!cand[0]) begin
          state_next = S_NEXT;
        end else begin
          init_div   = 1'b1;
          state_next = S_TRIAL;
        end
      end
      S_TRIAL: begin
        // The running square of the divisor replaces the d <= n / d test.
        if (sq <= SQ_WIDTH'(cand)) begin
          rem_start  = 1'b1;
          state_next = S_DIVIDE;
        end else begin
          set_found  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DIVIDE: begin
        if (rem_stat.done) begin
          if (rem_stat.is_zero) begin
            state_next = S_NEXT;
          end else begin
            adv_div    = 1'b1;
            state_next = S_TRIAL;
          end
        end
      end
      S_NEXT: begin
        // The search stops at the top of the range rather than wrapping.
        if (cand == '1) begin
          set_fail   = 1'b1;
          state_next = S_DONE;
        end else begin
          step_cand  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cand <= start_ext[VALUE_WIDTH-1:0];
    end else if (step_cand) begin
      cand <= cand + VALUE_WIDTH'(1);
    end
    if (init_div) begin
      div_d <= DIV_WIDTH'(3);
      sq    <= SQ_WIDTH'(9);
    end else if (adv_div) begin
      // (d + 2)^2 = d^2 + 4d + 4
      div_d <= div_d + DIV_WIDTH'(2);
      sq    <= sq + (SQ_WIDTH'(div_d) << 2) + SQ_WIDTH'(4);
    end
    if (set_found) begin
      prime_value <= cand_ext[IO_WIDTH-1:0];
      no_prime    <= 1'b0;
    end else if (set_fail) begin
      prime_value <= '0;
      no_prime    <= 1'b1;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while an answer is pending");

  a_odd_divisor: assert property (@(posedge clk) disable iff (rst)
    state == S_TRIAL |-> div_d[0] && div_d >= DIV_WIDTH'(3))
    else $error("trial divisor is not an odd value of at least three");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_prime |-> prime_value == '0)
    else $error("failed search reports a nonzero value");

  a_rem_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    rem_start |-> !rem_stat.busy && state == S_TRIAL)
    else $error("remainder started outside the trial step");

endmodule

`default_nettype wire

// ===== bench/tb_next_prime_finder.sv =====
// Self-checking testbench for next_prime_finder: directed, pressure and random start values.
`timescale 1ns / 1ps

module tb_next_prime_finder;
  import npf_pkg::*;

  localparam int SEARCH_W = VALUE_WIDTH_DEF;
  localparam longint unsigned RANGE_TOP = (64'd1 << SEARCH_W) - 64'd1;
  localparam int LONG_STALL = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [IO_WIDTH-1:0] prime;
    logic                flag;
  } prime_answer_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [IO_WIDTH-1:0] start_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [IO_WIDTH-1:0] prime_value;
  logic                no_prime;

  prime_answer_t pending_answers[$];
  int            mismatch_count = 0;
  logic          quiet_mode = 1'b0;
  int unsigned   stall_req = 0;
  int unsigned   stall_seen = 0;
  int unsigned   stall_left = 0;

  next_prime_finder u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_value(start_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prime_value(prime_value),
    .no_prime   (no_prime)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb_next_prime_finder failed");
    $finish;
  end

  function automatic bit is_trial_prime(input longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic prime_answer_t predict_next_prime(input logic [IO_WIDTH-1:0] value);
    longint unsigned n;
    prime_answer_t   ans;
    n = longint'(value) & RANGE_TOP;
    forever begin
      if (is_trial_prime(n)) begin
        ans.prime = n[IO_WIDTH-1:0];
        ans.flag  = 1'b0;
        return ans;
      end
      if (n == RANGE_TOP) break;
      n++;
    end
    ans.prime = '0;
    ans.flag  = 1'b1;
    return ans;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // The sender gap is decided here; valid stays high between back-to-back transactions.
  task automatic send_start(input logic [IO_WIDTH-1:0] value);
    int gap;
    gap = 0;
    if (!quiet_mode && $urandom_range(99) < 15) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_value <= value;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(predict_next_prime(value));
  endtask

  task automatic wait_for_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, quiet stretches, and long hold-offs on request.
  always @(posedge clk) begin
    if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (quiet_mode) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    prime_answer_t exp_ans;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected answer %0d flag %0b", prime_value, no_prime));
      end else begin
        exp_ans = pending_answers.pop_front();
        if (prime_value !== exp_ans.prime)
          report_mismatch($sformatf("prime_value %0d, want %0d", prime_value, exp_ans.prime));
        if (no_prime !== exp_ans.flag)
          report_mismatch($sformatf("no_prime %0b, want %0b", no_prime, exp_ans.flag));
      end
    end
  end

  task automatic test_small_starts();
    send_start(32'd0);
    send_start(32'd1);
    send_start(32'd2);
    send_start(32'd3);
    send_start(32'd4);
    send_start(32'd9);
    send_start(32'd24);
    send_start(32'd25);
  endtask

  // Squares of primes and long gaps exercise the divisor-squared bound.
  task automatic test_prime_boundaries();
    send_start(32'd961);
    send_start(32'd120);
    send_start(32'd65521);
    send_start(32'd65535);
    send_start(32'd1 << 20);
  endtask

  // Above the largest prime of the range the search stops and raises the flag.
  task automatic test_range_top();
    send_start(32'hFFFF_FFFF);
    send_start(32'hFFFF_FFFE);
  endtask

  task automatic test_backpressure();
    stall_req <= stall_req + 1;
    send_start(32'd10);
    send_start(32'd20);
    send_start(32'd30);
    send_start(32'd100);
  endtask

  task automatic test_drain_pause();
    send_start(32'd1000);
    send_start(32'd7);
    wait_for_answers();
    send_start(32'd2000);
    send_start(32'd13);
  endtask

  task automatic test_random(input int count);
    int          width;
    int          pick;
    logic [31:0] value;
    for (int i = 0; i < count; i++) begin
      quiet_mode <= (i < 25);
      pick = $urandom_range(99);
      if (pick < 5) begin
        value = $urandom_range(2);
      end else if (pick < 10) begin
        value = 32'hFFFF_FFFE | $urandom_range(1);
      end else begin
        width = $urandom_range(1, 18);
        value = $urandom & ((32'd1 << width) - 1);
      end
      send_start(value);
    end
    quiet_mode <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_starts();
    test_prime_boundaries();
    test_range_top();
    test_backpressure();
    test_drain_pause();
    test_random(80);
    wait_for_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_next_prime_finder passed");
    end else begin
      $display("tb_next_prime_finder failed");
    end
    $finish;
  end

endmodule
